// File: rtl/sbrb_pkg.sv
// ----------------------------------------------------------------------------
// Segmented byte ring buffer package
// Shared types, codes and constants for the ring buffer modules.
// ----------------------------------------------------------------------------
package sbrb_pkg;

  localparam int unsigned BufBytes  = 65536;
  localparam int unsigned SegDepth  = 32;
  localparam int unsigned InitBytes = 4096;
  localparam int unsigned MaxRead   = 32;
  localparam int unsigned PtrW      = $clog2(BufBytes);
  localparam int unsigned SegW      = $clog2(SegDepth);
  localparam int unsigned CntW      = SegW + 1;
  localparam int unsigned InitW     = $clog2(InitBytes);
  localparam int unsigned InitLenW  = InitW + 1;

  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_FINISH    = 3'd1,
    OP_READ_SEG  = 3'd2,
    OP_QUERY     = 3'd3,
    OP_READ_INIT = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_STATUS  = 3'd0,
    KIND_REMOVED = 3'd1,
    KIND_SEG_RDY = 3'd2,
    KIND_INIT_RDY = 3'd3,
    KIND_BYTE    = 3'd4,
    KIND_QUERY   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ERROR     = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  data_byte;
    logic        chunk_first;
    logic [15:0] chunk_size;
    logic        init_flag;
    logic [15:0] segment_ref;
    logic [15:0] read_offset;
    logic [5:0]  read_length;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  status_code;
    logic [15:0] ref_value;
    logic [7:0]  read_byte;
    logic [15:0] bytes_free;
    logic [5:0]  segments_avail;
    logic [15:0] tail_ref;
    logic        last;
  } rsp_t;

endpackage

// File: rtl/sbrb_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel that carries one request.
// ----------------------------------------------------------------------------
interface sbrb_req_if;
  import sbrb_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sbrb_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel interface
// Valid/ready channel that carries one result.
// ----------------------------------------------------------------------------
interface sbrb_rsp_if;
  import sbrb_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sbrb_front.sv
// ----------------------------------------------------------------------------
// Request front end
// Takes requests and queues them for the back end.
// ----------------------------------------------------------------------------
module sbrb_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  sbrb_req_if.sink       req,
  output sbrb_pkg::req_t q_data_o,
  output logic           q_valid_o,
  input  logic           q_pop_i
);
  import sbrb_pkg::*;

  req_t       fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;

  assign req.ready = (cnt_q != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= req.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !q_pop_i) |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("push lost");

endmodule

// File: rtl/sbrb_back.sv
// ----------------------------------------------------------------------------
// Ring buffer back end
// Executes queued requests against the ring, descriptor queue and init store.
// ----------------------------------------------------------------------------
module sbrb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [4:0]     max_segments_i,
  input  sbrb_pkg::req_t q_data_i,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  sbrb_rsp_if.source     rsp
);
  import sbrb_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_EVICT   = 11'b00000000010,
    S_ECHK    = 11'b00000000100,
    S_SEARCH  = 11'b00000001000,
    S_SRCHK   = 11'b00000010000,
    S_RADDR   = 11'b00000100000,
    S_RDATA   = 11'b00001000000,
    S_COPYA   = 11'b00010000000,
    S_COPYD   = 11'b00100000000,
    S_EMIT    = 11'b01000000000,
    S_QUERY   = 11'b10000000000
  } state_e;

  state_e state_q;
  req_t   cur_q;

  logic [7:0]  ring_mem [BufBytes];
  logic [7:0]  init_mem [InitBytes];
  logic [PtrW-1:0] dstart_mem [SegDepth];
  logic [15:0] dlen_mem [SegDepth];
  logic [15:0] dref_mem [SegDepth];

  logic [PtrW-1:0] rptr_q, wptr_q, ostart_q;
  logic [15:0]     olen_q, nref_q;
  logic [SegW-1:0] head_q;
  logic [CntW-1:0] qcnt_q;
  logic            dropped_q;
  logic [InitLenW-1:0] ilen_q;

  // Registered descriptor read port.
  logic [SegW-1:0] didx;
  logic [PtrW-1:0] d_start_q;
  logic [15:0]     d_len_q, d_ref_q;
  logic [15:0]     q_lastref_q;

  logic [7:0] ring_rd_q, init_rd_q;
  logic [PtrW-1:0] raddr_q;
  logic [15:0]     cnt_q;
  logic [15:0]     rem_q;
  logic [CntW-1:0] scan_q;
  logic            src_init_q;
  logic            trunc_q;
  logic [15:0]     fref_q;

  logic rsp_put_q, rsp_take_q;
  logic rsp_pend;
  rsp_t rsp_q;
  rsp_t qry_rsp;

  logic [PtrW-1:0] free_bytes;
  logic            need_evict;
  logic            out_free;
  logic [15:0]     want;

  assign rsp_pend   = rsp_put_q != rsp_take_q;
  assign free_bytes = rptr_q - wptr_q - PtrW'(1);
  assign need_evict = ({{(32-PtrW){1'b0}}, free_bytes} < {16'd0, cur_q.chunk_size})
                      || (qcnt_q > CntW'(max_segments_i));
  assign out_free   = !rsp_pend || rsp.ready;
  assign rsp.valid  = rsp_pend;
  assign rsp.data   = rsp_q;
  assign want       = (cur_q.read_length > 6'd32) ? 16'd32 : {10'd0, cur_q.read_length};

  always_comb begin
    didx = head_q;
    if (state_q == S_IDLE && q_data_i.opcode == OP_QUERY) begin
      didx = head_q;
    end else if (state_q == S_SEARCH || state_q == S_SRCHK) begin
      didx = head_q + scan_q[SegW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    d_start_q   <= dstart_mem[didx];
    d_len_q     <= dlen_mem[didx];
    d_ref_q     <= dref_mem[didx];
    q_lastref_q <= dref_mem[head_q + SegW'(qcnt_q - CntW'(1))];
    ring_rd_q   <= ring_mem[raddr_q];
    init_rd_q   <= init_mem[raddr_q[InitW-1:0]];
  end

  function automatic rsp_t mk(input logic [2:0] k, input logic [1:0] s,
                              input logic [15:0] r, input logic [7:0] b,
                              input logic l);
    rsp_t x;
    x = '0;
    x.kind = k;
    x.status_code = s;
    x.ref_value = r;
    x.read_byte = b;
    x.last = l;
    return x;
  endfunction

  always_comb begin
    qry_rsp = mk(KIND_QUERY, ST_OK, (qcnt_q != '0) ? q_lastref_q : 16'd0, '0, 1'b1);
    qry_rsp.bytes_free     = 16'(free_bytes);
    qry_rsp.segments_avail = 6'(qcnt_q);
    qry_rsp.tail_ref       = (qcnt_q != '0) ? d_ref_q : 16'd0;
  end

  logic ring_we, init_we, desc_we;
  logic [PtrW-1:0]  ring_wa;
  logic [7:0]       ring_wd;
  logic [InitW-1:0] init_wa;
  logic [SegW-1:0]  desc_wa;

  assign ring_we = (state_q == S_IDLE) && q_valid_i && out_free &&
                   q_data_i.opcode == OP_WRITE && !q_data_i.chunk_first && !dropped_q;
  assign ring_wa = wptr_q;
  assign ring_wd = ring_we ? q_data_i.data_byte : cur_q.data_byte;
  assign desc_wa = head_q + qcnt_q[SegW-1:0];
  assign desc_we = (state_q == S_IDLE) && q_valid_i && out_free &&
                   q_data_i.opcode == OP_FINISH && wptr_q != ostart_q &&
                   olen_q != 16'd0 && qcnt_q < CntW'(SegDepth);
  assign init_we = (state_q == S_COPYD);
  assign init_wa = cnt_q[InitW-1:0];

  always_ff @(posedge clk_i) begin
    if (ring_we || (state_q == S_ECHK && !need_evict)) ring_mem[ring_wa] <= ring_wd;
    if (init_we) init_mem[init_wa] <= ring_rd_q;
    if (desc_we) begin
      dstart_mem[desc_wa] <= ostart_q;
      dlen_mem[desc_wa]   <= olen_q;
      dref_mem[desc_wa]   <= nref_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_take_q <= 1'b0;
    end else if (rsp_pend && rsp.ready) begin
      rsp_take_q <= ~rsp_take_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      rptr_q     <= '0;
      wptr_q     <= PtrW'(1);
      ostart_q   <= PtrW'(1);
      olen_q     <= '0;
      nref_q     <= '0;
      head_q     <= '0;
      qcnt_q     <= '0;
      dropped_q  <= 1'b0;
      ilen_q     <= '0;
      rsp_put_q  <= 1'b0;
      rsp_q      <= '0;
      cur_q      <= '0;
      raddr_q    <= '0;
      cnt_q      <= '0;
      rem_q      <= '0;
      scan_q     <= '0;
      src_init_q <= 1'b0;
      trunc_q    <= 1'b0;
      fref_q     <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (q_valid_i && out_free) begin
            cur_q <= q_data_i;
            case (q_data_i.opcode)
              OP_WRITE: begin
                if (q_data_i.chunk_first) begin
                  if (q_data_i.chunk_size == 16'd0) begin
                    dropped_q <= 1'b1;
                    rsp_q     <= mk(KIND_STATUS, ST_ERROR, '0, '0, 1'b1);
                    rsp_put_q <= ~rsp_put_q;
                  end else begin
                    state_q <= S_ECHK;
                  end
                end else if (dropped_q) begin
                  rsp_q     <= mk(KIND_STATUS, ST_ERROR, '0, '0, 1'b1);
                  rsp_put_q <= ~rsp_put_q;
                end else begin
                  wptr_q <= wptr_q + PtrW'(1);
                  if (olen_q != 16'hFFFF) olen_q <= olen_q + 16'd1;
                  rsp_q     <= mk(KIND_STATUS, ST_OK, '0, '0, 1'b1);
                  rsp_put_q <= ~rsp_put_q;
                end
              end
              OP_FINISH: begin
                if (!desc_we) begin
                  rsp_q     <= mk(KIND_STATUS, ST_ERROR, '0, '0, 1'b1);
                  rsp_put_q <= ~rsp_put_q;
                end else begin
                  qcnt_q   <= qcnt_q + CntW'(1);
                  ostart_q <= wptr_q;
                  olen_q   <= '0;
                  nref_q   <= nref_q + 16'd1;
                  if (!q_data_i.init_flag) begin
                    rsp_q     <= mk(KIND_SEG_RDY, ST_OK, nref_q, '0, 1'b1);
                    rsp_put_q <= ~rsp_put_q;
                  end else if (qcnt_q != '0) begin
                    rsp_q     <= mk(KIND_STATUS, ST_ERROR, nref_q, '0, 1'b1);
                    rsp_put_q <= ~rsp_put_q;
                  end else begin
                    fref_q  <= nref_q;
                    trunc_q <= olen_q > 16'(InitBytes);
                    ilen_q  <= (olen_q > 16'(InitBytes)) ? InitLenW'(InitBytes)
                                                          : InitLenW'(olen_q);
                    rem_q   <= (olen_q > 16'(InitBytes)) ? 16'(InitBytes) : olen_q;
                    raddr_q <= ostart_q;
                    cnt_q   <= '0;
                    state_q <= (olen_q == 16'd0) ? S_EMIT : S_COPYA;
                  end
                end
              end
              OP_READ_SEG: begin
                scan_q  <= '0;
                state_q <= S_SEARCH;
              end
              OP_QUERY: state_q <= S_QUERY;
              OP_READ_INIT: begin
                if (q_data_i.read_length == 6'd0 ||
                    {q_data_i.read_offset} >= {3'd0, ilen_q}) begin
                  rsp_q     <= mk(KIND_STATUS, ST_ERROR, '0, '0, 1'b1);
                  rsp_put_q <= ~rsp_put_q;
                end else begin
                  src_init_q <= 1'b1;
                  raddr_q    <= PtrW'(q_data_i.read_offset);
                  rem_q      <= 16'({3'd0, ilen_q} - q_data_i.read_offset);
                  cnt_q      <= '0;
                  state_q    <= S_RADDR;
                end
              end
              default: begin
                rsp_q     <= mk(KIND_STATUS, ST_ERROR, '0, '0, 1'b1);
                rsp_put_q <= ~rsp_put_q;
              end
            endcase
          end
        end
        S_ECHK: begin
          if (out_free) begin
            if (need_evict && qcnt_q != '0) begin
              state_q <= S_EVICT;
            end else if (need_evict) begin
              dropped_q <= 1'b1;
              rsp_q     <= mk(KIND_STATUS, ST_ERROR, '0, '0, 1'b1);
              rsp_put_q <= ~rsp_put_q;
              state_q   <= S_IDLE;
            end else begin
              dropped_q <= 1'b0;
              wptr_q    <= wptr_q + PtrW'(1);
              if (olen_q != 16'hFFFF) olen_q <= olen_q + 16'd1;
              rsp_q     <= mk(KIND_STATUS, ST_OK, '0, '0, 1'b1);
              rsp_put_q <= ~rsp_put_q;
              state_q   <= S_IDLE;
            end
          end
        end
        S_EVICT: begin
          if (out_free) begin
            rptr_q    <= d_start_q + PtrW'(d_len_q);
            rsp_q     <= mk(KIND_REMOVED, ST_OK, d_ref_q, '0, 1'b0);
            rsp_put_q <= ~rsp_put_q;
            head_q    <= head_q + SegW'(1);
            qcnt_q    <= qcnt_q - CntW'(1);
            state_q   <= S_ECHK;
          end
        end
        S_SEARCH: state_q <= S_SRCHK;
        S_SRCHK: begin
          if (scan_q >= qcnt_q) begin
            if (out_free) begin
              rsp_q     <= mk(KIND_STATUS, ST_ERROR, '0, '0, 1'b1);
              rsp_put_q <= ~rsp_put_q;
              state_q   <= S_IDLE;
            end
          end else if (d_ref_q == cur_q.segment_ref) begin
            if (out_free) begin
              if (cur_q.read_length == 6'd0 || cur_q.read_offset >= d_len_q) begin
                rsp_q     <= mk(KIND_STATUS, ST_ERROR, '0, '0, 1'b1);
                rsp_put_q <= ~rsp_put_q;
                state_q   <= S_IDLE;
              end else begin
                src_init_q <= 1'b0;
                raddr_q    <= d_start_q + PtrW'(cur_q.read_offset);
                rem_q      <= d_len_q - cur_q.read_offset;
                cnt_q      <= '0;
                state_q    <= S_RADDR;
              end
            end
          end else begin
            scan_q  <= scan_q + CntW'(1);
            state_q <= S_SEARCH;
          end
        end
        S_RADDR: state_q <= S_RDATA;
        S_RDATA: begin
          if (out_free) begin
            rsp_q <= mk(KIND_BYTE, ST_OK, src_init_q ? 16'd0 : cur_q.segment_ref,
                        src_init_q ? init_rd_q : ring_rd_q,
                        (cnt_q + 16'd1 == rem_q) || (cnt_q + 16'd1 == want));
            rsp_put_q <= ~rsp_put_q;
            cnt_q     <= cnt_q + 16'd1;
            raddr_q   <= raddr_q + PtrW'(1);
            state_q   <= ((cnt_q + 16'd1 == rem_q) || (cnt_q + 16'd1 == want))
                         ? S_IDLE : S_RADDR;
          end
        end
        S_COPYA: state_q <= S_COPYD;
        S_COPYD: begin
          cnt_q   <= cnt_q + 16'd1;
          raddr_q <= raddr_q + PtrW'(1);
          state_q <= (cnt_q + 16'd1 == rem_q) ? S_EMIT : S_COPYA;
        end
        S_EMIT: begin
          if (out_free) begin
            qcnt_q    <= '0;
            head_q    <= '0;
            rptr_q    <= '0;
            wptr_q    <= PtrW'(1);
            ostart_q  <= PtrW'(1);
            olen_q    <= '0;
            nref_q    <= '0;
            rsp_q     <= mk(KIND_INIT_RDY, trunc_q ? ST_TRUNCATED : ST_OK, fref_q, '0, 1'b1);
            rsp_put_q <= ~rsp_put_q;
            state_q   <= S_IDLE;
          end
        end
        S_QUERY: begin
          if (out_free) begin
            rsp_q     <= qry_rsp;
            rsp_put_q <= ~rsp_put_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i && out_free;

  assert property (@(posedge clk_i) disable iff (!rst_ni) qcnt_q <= CntW'(SegDepth))
    else $error("descriptor count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_pend && !rsp.ready) |=> rsp_pend && $stable(rsp_q))
    else $error("held result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVICT) |-> qcnt_q != '0)
    else $error("evict with empty queue");

endmodule

// File: rtl/segmented_byte_ring_buffer.sv
// ----------------------------------------------------------------------------
// Segmented byte ring buffer
// Byte ring of media segments with a descriptor queue and an init store.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid/ready   | opcode, data, chunk, read fields
//   rsp     | out | valid/ready   | kind, status, refs, byte, counts, last
//   cfg     | in  | write enable  | max_segments
//
// A first byte of a chunk passes an eviction check and a following byte is written directly
// from idle; each eviction adds an evict step ahead of a new check.
// A reference search takes a search and a check step per descriptor scanned, a read an
// address and a data step per byte, and an init copy an address and a copy step per byte.
// Reset is asynchronous and active low; a two-entry queue decouples input from back end.
// ----------------------------------------------------------------------------
module segmented_byte_ring_buffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  sbrb_req_if.sink   req,
  sbrb_rsp_if.source rsp
);
  import sbrb_pkg::*;

  logic [4:0] max_seg_q;
  req_t       q_data;
  logic       q_valid, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_seg_q <= 5'd16;
    end else if (cfg_we_i) begin
      max_seg_q <= cfg_wdata_i;
    end
  end

  sbrb_front u_front (
    .clk_i,
    .rst_ni,
    .req,
    .q_data_o  (q_data),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  sbrb_back u_back (
    .clk_i,
    .rst_ni,
    .max_segments_i (max_seg_q),
    .q_data_i       (q_data),
    .q_valid_i      (q_valid),
    .q_pop_o        (q_pop),
    .rsp
  );

endmodule
